// File: hdl/ndos_pkg.sv
// Shared types, constants and the nibble reduction table for the order selector.
package ndos_pkg;

   localparam int DefaultMaxAlgos = 15;
   localparam int IdxWidth = 4;
   localparam int ByteWidth = 8;

   localparam logic [1:0] SEL_LOW  = 2'd0;
   localparam logic [1:0] SEL_HIGH = 2'd1;
   localparam logic [1:0] SEL_FILL = 2'd2;

   typedef struct packed {
      logic [ByteWidth-1:0] seed_byte;
      logic                 seed_end;
   } req_type;

   typedef struct packed {
      logic [IdxWidth-1:0] chosen_index;
      logic [IdxWidth-1:0] order_position;
      logic                order_done;
   } rsp_type;

   typedef struct packed {
      logic       load;
      logic       take;
      logic       fill_start;
      logic       clear;
      logic [1:0] sel;
   } cmd_type;

   typedef struct packed {
      logic emit_req;
      logic fill_over;
      logic last;
      logic out_free;
   } sts_type;

   function automatic logic [1023:0] build_mod_table();
      logic [1023:0] tbl;
      int            nn;
      int            nb;
      int            rem;
      tbl = '0;
      for (int i = 0; i < 256; i++) begin
         nn = i >> 4;
         nb = i & 15;
         if (nn != 0) begin
            rem = nb;
            for (int k = 0; k < 16; k++) begin
               if (rem >= nn) begin
                  rem = rem - nn;
               end
            end
            tbl[i*4 +: 4] = 4'(rem);
         end
      end
      return tbl;
   endfunction

   localparam logic [1023:0] MOD_TABLE = build_mod_table();

endpackage

// File: hdl/nibble_driven_order_selector.sv
// Top level of the nibble-driven order selector: controller, datapath and checks.
//
//   Channel   Direction  Handshake            Payload
//   req_      in         req_valid/req_stall  req_type: seed_byte, seed_end
//   rsp_      out        rsp_valid/rsp_stall  rsp_type: chosen_index, order_position, order_done
//   csr_      in         csr_valid/csr_ready  algo_count, 4 bits
//
// A seed byte takes one step per nibble, low nibble first; a step waits while the result
// register holds a stalled item. A byte that ends the sequence is followed by a fill walk over
// the indices from zero up to the last unseen index and a step that clears the seen mask and
// count; the next byte is then taken only from the idle state.
// The result register stalls the nibble or fill step that wants to emit an item.
// Reset sets algo_count to 15 and clears the seen mask, the count and the result valid flag.
module nibble_driven_order_selector #(
   parameter int MAX_ALGOS = ndos_pkg::DefaultMaxAlgos
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  ndos_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output ndos_pkg::rsp_type rsp_data,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [3:0]        csr_data
);
   import ndos_pkg::*;

   cmd_type cmd;
   sts_type sts;

   assign csr_ready = 1'b1;

   ndos_control u_control (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   ndos_datapath #(
      .MAX_ALGOS (MAX_ALGOS)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .csr_write (csr_valid && csr_ready),
      .csr_data  (csr_data),
      .cmd       (cmd),
      .sts       (sts),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (cmd.take && sts.emit_req) |-> sts.out_free)
      else $error("Result register overwritten while an item is pending.");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("Input accepted again before the high nibble was handled.");

   a_position_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.order_position != 4'd15))
      else $error("Order position beyond the largest count.");

endmodule

// File: hdl/ndos_datapath.sv
// Datapath of the order selector: seed byte, seen mask, count, fill index and result register.
module ndos_datapath #(
   parameter int MAX_ALGOS = ndos_pkg::DefaultMaxAlgos
) (
   input  logic             clock,
   input  logic             reset,
   input  ndos_pkg::req_type req_data,
   input  logic             csr_write,
   input  logic [3:0]       csr_data,
   input  ndos_pkg::cmd_type cmd,
   output ndos_pkg::sts_type sts,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output ndos_pkg::rsp_type rsp_data
);
   import ndos_pkg::*;

   localparam int MaskIdxW = (MAX_ALGOS > 1) ? $clog2(MAX_ALGOS) : 1;
   localparam logic [4:0] MaxCount = 5'(MAX_ALGOS);

   logic [3:0]           algo_ff;
   logic [ByteWidth-1:0] byte_ff;
   logic                 last_ff;
   logic [MAX_ALGOS-1:0] mask_ff, mask_in;
   logic [3:0]           count_ff, count_in;
   logic [3:0]           fill_ff, fill_in;
   logic                 out_valid_ff, out_valid_in;
   rsp_type              out_ff, out_in;

   logic [3:0] n_eff;
   logic [3:0] nib;
   logic [3:0] nib_idx;
   logic [3:0] idx;
   logic       active;
   logic       seen;
   logic       fill_over;
   logic       emit_req;
   logic       out_free;
   logic [4:0] count_next;

   always_comb begin
      if (algo_ff == 4'd0) begin
         n_eff = 4'd1;
      end else if ({1'b0, algo_ff} > MaxCount) begin
         n_eff = MaxCount[3:0];
      end else begin
         n_eff = algo_ff;
      end
   end

   assign nib        = (cmd.sel == SEL_HIGH) ? byte_ff[7:4] : byte_ff[3:0];
   assign nib_idx    = MOD_TABLE[{n_eff, nib}*4 +: 4];
   assign idx        = (cmd.sel == SEL_FILL) ? fill_ff : nib_idx;
   assign active     = count_ff < n_eff;
   assign seen       = mask_ff[idx[MaskIdxW-1:0]];
   assign fill_over  = !((fill_ff < n_eff) && active);
   assign emit_req   = (cmd.sel == SEL_FILL) ? (!fill_over && !seen) : (active && !seen);
   assign out_free   = !out_valid_ff || !rsp_stall;
   assign count_next = {1'b0, count_ff} + 5'd1;

   assign sts.emit_req  = emit_req;
   assign sts.fill_over = fill_over;
   assign sts.last      = last_ff;
   assign sts.out_free  = out_free;

   always_comb begin
      mask_in      = mask_ff;
      count_in     = count_ff;
      fill_in      = fill_ff;
      out_in       = out_ff;
      out_valid_in = out_valid_ff && rsp_stall;
      if (cmd.take && emit_req) begin
         mask_in[idx[MaskIdxW-1:0]] = 1'b1;
         count_in                   = count_next[3:0];
         out_in.chosen_index        = idx;
         out_in.order_position      = count_ff;
         out_in.order_done          = (count_next == {1'b0, n_eff});
         out_valid_in               = 1'b1;
      end
      if (cmd.take && (cmd.sel == SEL_FILL)) begin
         fill_in = fill_ff + 4'd1;
      end
      if (cmd.fill_start) begin
         fill_in = 4'd0;
      end
      if (cmd.clear) begin
         mask_in  = '0;
         count_in = 4'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         algo_ff      <= 4'd15;
         mask_ff      <= '0;
         count_ff     <= 4'd0;
         out_valid_ff <= 1'b0;
      end else begin
         if (csr_write) begin
            algo_ff <= csr_data;
         end
         mask_ff      <= mask_in;
         count_ff     <= count_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         byte_ff <= req_data.seed_byte;
         last_ff <= req_data.seed_end;
      end
      fill_ff <= fill_in;
      out_ff  <= out_in;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;

endmodule

// File: hdl/ndos_control.sv
// Controller state machine that sequences low nibble, high nibble and fill steps.
module ndos_control (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  ndos_pkg::sts_type sts,
   output ndos_pkg::cmd_type cmd
);
   import ndos_pkg::*;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_LOW  = 2'd1;
   localparam logic [1:0] ST_HIGH = 2'd2;
   localparam logic [1:0] ST_FILL = 2'd3;

   logic [1:0] state_ff, state_in;
   logic       step_ok;
   logic       accept_ok;

   assign step_ok = !sts.emit_req || sts.out_free;

   always_comb begin
      accept_ok = 1'b0;
      case (state_ff)
         ST_IDLE: accept_ok = 1'b1;
         ST_HIGH: accept_ok = step_ok && !sts.last;
         default: accept_ok = 1'b0;
      endcase
   end

   assign req_stall = !accept_ok;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      cmd.load = accept_ok && req_valid;
      case (state_ff)
         ST_IDLE: begin
            cmd.sel = SEL_LOW;
            if (req_valid) begin
               state_in = ST_LOW;
            end
         end
         ST_LOW: begin
            cmd.sel  = SEL_LOW;
            cmd.take = step_ok;
            if (step_ok) begin
               state_in = ST_HIGH;
            end
         end
         ST_HIGH: begin
            cmd.sel  = SEL_HIGH;
            cmd.take = step_ok;
            if (step_ok) begin
               if (sts.last) begin
                  cmd.fill_start = 1'b1;
                  state_in       = ST_FILL;
               end else if (req_valid) begin
                  state_in = ST_LOW;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_FILL: begin
            cmd.sel = SEL_FILL;
            if (sts.fill_over) begin
               cmd.clear = 1'b1;
               state_in  = ST_IDLE;
            end else begin
               cmd.take = step_ok;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule
